>>> hdl/ssplit_pkg.sv
// Shared constants, types and helpers for the SQL statement splitter.
package ssplit_pkg;

	// Default depth of the trailing whitespace hold store
	localparam int HOLD_DEPTH_DEF = 16;

	// Lexer modes
	localparam logic [2:0] MODE_NORMAL = 3'd0;
	localparam logic [2:0] MODE_SQUOTE = 3'd1;
	localparam logic [2:0] MODE_DQUOTE = 3'd2;
	localparam logic [2:0] MODE_LINE   = 3'd3;
	localparam logic [2:0] MODE_BLOCK  = 3'd4;

	// Held lookahead character
	localparam logic [1:0] PEND_NONE  = 2'd0;
	localparam logic [1:0] PEND_DASH  = 2'd1;
	localparam logic [1:0] PEND_SLASH = 2'd2;

	// Characters of interest
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_NL    = 8'h0A;

	// Source of an emitted result
	localparam logic [1:0] SRC_CUR  = 2'd0;
	localparam logic [1:0] SRC_MARK = 2'd1;
	localparam logic [1:0] SRC_HOLD = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic       load;        // latch a new input transaction
		logic       pop;         // retire current operation
		logic       emit;        // push a new result into the stage
		logic [1:0] src;         // where the result comes from
		logic       flag;        // hold_overflow for flushed bytes
		logic       store;       // append current char to hold store
		logic       set_content; // statement has visible content
		logic       clear_stmt;  // end of statement bookkeeping
		logic       flush_start; // rewind flush pointer
		logic       flush_step;  // advance flush pointer
		logic       flush_done;  // hold store emptied
		logic       final_push;  // move staged result out with last set
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic op_none;
		logic op_end;
		logic cur_space;
		logic has_content;
		logic cnt_zero;
		logic cnt_full;
		logic flush_last;
		logic emit_ok;
		logic out_free;
		logic stg_valid;
	} sts_t;

	// C-locale whitespace
	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

endpackage

>>> hdl/ssplit_ctrl.sv
// Sequencer for the statement splitter: walks the operations of one transaction.
module ssplit_ctrl
	import ssplit_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DISP  = 2'd1;
	localparam logic [1:0] ST_PREP  = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0] state_q, state_d;
	logic       flag_q, flag_d;

	assign in_ready = (state_q == ST_IDLE);

	// Next state and command decode
	always_comb begin
		state_d = state_q;
		flag_d  = flag_q;
		cmd     = '0;
		cmd.src = SRC_CUR;
		cmd.flag = flag_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DISP;
				end
			end
			ST_DISP: begin
				if (sts.op_none) begin
					if (!sts.stg_valid) begin
						state_d = ST_IDLE;
					end else if (sts.out_free) begin
						cmd.final_push = 1'b1;
						state_d        = ST_IDLE;
					end
				end else if (sts.op_end) begin
					if (!sts.has_content) begin
						cmd.clear_stmt = 1'b1;
						cmd.pop        = 1'b1;
					end else if (sts.emit_ok) begin
						cmd.emit       = 1'b1;
						cmd.src        = SRC_MARK;
						cmd.clear_stmt = 1'b1;
						cmd.pop        = 1'b1;
					end
				end else if (sts.cur_space) begin
					if (!sts.has_content) begin
						cmd.pop = 1'b1;
					end else if (sts.cnt_full) begin
						cmd.flush_start = 1'b1;
						flag_d          = 1'b1;
						state_d         = ST_PREP;
					end else begin
						cmd.store = 1'b1;
						cmd.pop   = 1'b1;
					end
				end else begin
					if (!sts.cnt_zero) begin
						cmd.flush_start = 1'b1;
						flag_d          = 1'b0;
						state_d         = ST_PREP;
					end else if (sts.emit_ok) begin
						cmd.emit        = 1'b1;
						cmd.src         = SRC_CUR;
						cmd.set_content = 1'b1;
						cmd.pop         = 1'b1;
					end
				end
			end
			ST_PREP: begin
				// first hold entry is being read
				state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (sts.emit_ok) begin
					cmd.emit       = 1'b1;
					cmd.src        = SRC_HOLD;
					cmd.flush_step = 1'b1;
					if (sts.flush_last) begin
						cmd.flush_done = 1'b1;
						state_d        = ST_DISP;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			flag_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			flag_q  <= flag_d;
		end
	end

endmodule

>>> hdl/ssplit_dp.sv
// Datapath: lexer state, operation slots, whitespace hold memory, result registers.
module ssplit_dp
	import ssplit_pkg::*;
#(
	parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       action,
	input  logic [7:0] in_byte,
	input  cmd_t       cmd,
	output sts_t       sts,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       kind,
	output logic [7:0] out_byte,
	output logic       hold_overflow,
	output logic       last
);

	localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
	localparam int CW = $clog2(HOLD_DEPTH + 1);

	// Lexer state
	logic [2:0] mode_q, mode_d;
	logic       star_q, star_d;
	logic [1:0] pend_q, pend_d;

	// Operation slots: 0 = released lookahead char, 1 = current char, 2 = end
	logic [2:0] op_v_q, op_v_d;
	logic [7:0] opa_q, opa_d, opb_q, opb_d;

	// Statement and hold store state
	logic          content_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] fidx_q;
	logic [7:0]    hold_mem [HOLD_DEPTH];
	logic [7:0]    rd_q;
	logic [CW-1:0] fnext;
	logic [AW-1:0] rd_addr;

	// Staged result and output register
	logic       stg_v_q;
	logic       stg_kind_q, stg_flag_q;
	logic [7:0] stg_byte_q;
	logic       out_v_q;
	logic       out_kind_q, out_flag_q, out_last_q;
	logic [7:0] out_byte_q;

	logic [7:0] cur_char;
	logic       new_kind, new_flag;
	logic [7:0] new_byte;
	logic       out_free, push;

	// Lexer decode of an incoming transaction
	always_comb begin
		mode_d = mode_q;
		star_d = star_q;
		pend_d = pend_q;
		op_v_d = 3'b000;
		opa_d  = (pend_q == PEND_DASH) ? CH_DASH : CH_SLASH;
		opb_d  = in_byte;
		if (action) begin
			op_v_d[0] = (mode_q == MODE_NORMAL) && (pend_q != PEND_NONE);
			op_v_d[2] = 1'b1;
			mode_d    = MODE_NORMAL;
			star_d    = 1'b0;
			pend_d    = PEND_NONE;
		end else begin
			case (mode_q)
				MODE_LINE: begin
					if (in_byte == CH_NL) begin
						mode_d    = MODE_NORMAL;
						op_v_d[1] = 1'b1;
					end
				end
				MODE_BLOCK: begin
					if (star_q && (in_byte == CH_SLASH)) begin
						mode_d = MODE_NORMAL;
						star_d = 1'b0;
					end else begin
						star_d = (in_byte == CH_STAR);
					end
				end
				MODE_SQUOTE: begin
					op_v_d[1] = 1'b1;
					if (in_byte == CH_SQ) mode_d = MODE_NORMAL;
				end
				MODE_DQUOTE: begin
					op_v_d[1] = 1'b1;
					if (in_byte == CH_DQ) mode_d = MODE_NORMAL;
				end
				default: begin
					mode_d = MODE_NORMAL;
					pend_d = PEND_NONE;
					if ((pend_q == PEND_DASH) && (in_byte == CH_DASH)) begin
						mode_d = MODE_LINE;
					end else if ((pend_q == PEND_SLASH) && (in_byte == CH_STAR)) begin
						mode_d = MODE_BLOCK;
						star_d = 1'b0;
					end else begin
						op_v_d[0] = (pend_q != PEND_NONE);
						if (in_byte == CH_SQ) begin
							mode_d    = MODE_SQUOTE;
							op_v_d[1] = 1'b1;
						end else if (in_byte == CH_DQ) begin
							mode_d    = MODE_DQUOTE;
							op_v_d[1] = 1'b1;
						end else if (in_byte == CH_DASH) begin
							pend_d = PEND_DASH;
						end else if (in_byte == CH_SLASH) begin
							pend_d = PEND_SLASH;
						end else if (in_byte == CH_SEMI) begin
							op_v_d[2] = 1'b1;
						end else begin
							op_v_d[1] = 1'b1;
						end
					end
				end
			endcase
		end
	end

	// Current operation is the lowest pending slot
	assign cur_char = op_v_q[0] ? opa_q : opb_q;

	// Flush read address: look one entry ahead while stepping
	assign fnext   = CW'(fidx_q) + CW'(1);
	assign rd_addr = cmd.flush_step ? ((fnext < CW'(HOLD_DEPTH)) ? fnext[AW-1:0] : '0)
	                                : fidx_q;

	// New result selection
	always_comb begin
		case (cmd.src)
			SRC_MARK: begin
				new_kind = 1'b1;
				new_byte = 8'h00;
				new_flag = 1'b0;
			end
			SRC_HOLD: begin
				new_kind = 1'b0;
				new_byte = rd_q;
				new_flag = cmd.flag;
			end
			default: begin
				new_kind = 1'b0;
				new_byte = cur_char;
				new_flag = 1'b0;
			end
		endcase
	end

	assign out_free = !out_v_q || out_ready;
	assign push     = (cmd.emit && stg_v_q) || cmd.final_push;

	// Status to controller
	always_comb begin
		sts.op_none     = (op_v_q == 3'b000);
		sts.op_end      = !op_v_q[0] && !op_v_q[1] && op_v_q[2];
		sts.cur_space   = is_space(cur_char);
		sts.has_content = content_q;
		sts.cnt_zero    = (cnt_q == '0);
		sts.cnt_full    = (cnt_q == CW'(HOLD_DEPTH));
		sts.flush_last  = (fnext == cnt_q);
		sts.emit_ok     = !stg_v_q || out_free;
		sts.out_free    = out_free;
		sts.stg_valid   = stg_v_q;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_NORMAL;
			star_q    <= 1'b0;
			pend_q    <= PEND_NONE;
			op_v_q    <= 3'b000;
			content_q <= 1'b0;
			cnt_q     <= '0;
			fidx_q    <= '0;
			stg_v_q   <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				mode_q <= mode_d;
				star_q <= star_d;
				pend_q <= pend_d;
				op_v_q <= op_v_d;
			end else if (cmd.pop) begin
				if (op_v_q[0]) op_v_q[0] <= 1'b0;
				else if (op_v_q[1]) op_v_q[1] <= 1'b0;
				else op_v_q[2] <= 1'b0;
			end
			if (cmd.set_content) content_q <= 1'b1;
			if (cmd.clear_stmt) begin
				content_q <= 1'b0;
				cnt_q     <= '0;
			end else if (cmd.flush_done) begin
				cnt_q <= '0;
			end else if (cmd.store) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.flush_start) fidx_q <= '0;
			else if (cmd.flush_step) fidx_q <= fnext[AW-1:0];
			if (cmd.emit) stg_v_q <= 1'b1;
			else if (cmd.final_push) stg_v_q <= 1'b0;
			if (push) out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			opa_q <= opa_d;
			opb_q <= opb_d;
		end
		if (cmd.emit) begin
			stg_kind_q <= new_kind;
			stg_byte_q <= new_byte;
			stg_flag_q <= new_flag;
		end
		if (push) begin
			out_kind_q <= stg_kind_q;
			out_byte_q <= stg_byte_q;
			out_flag_q <= stg_flag_q;
			out_last_q <= cmd.final_push;
		end
	end

	// Whitespace hold memory
	always_ff @(posedge clk) begin
		if (cmd.store) hold_mem[cnt_q[AW-1:0]] <= cur_char;
		rd_q <= hold_mem[rd_addr];
	end

	assign out_valid     = out_v_q;
	assign kind          = out_kind_q;
	assign out_byte      = out_byte_q;
	assign hold_overflow = out_flag_q;
	assign last          = out_last_q;

endmodule

>>> hdl/sql_statement_splitter_core.sv
// Top level of the SQL statement splitter with comment stripping.
//
//  Channel  Handshake            Payload
//  input    in_valid/in_ready    action, in_byte
//  output   out_valid/out_ready  kind, out_byte, hold_overflow, last
//
// An input transaction is loaded, then each of its slot operations is dispatched
// (released lookahead char, current char, end of statement), whether or not it
// yields a result; a hold store flush adds a start step and a memory read before
// its bytes go out. A byte that opens no operation only passes load and dispatch.
// Reset clears lexer, statement and handshake state; the hold memory needs none.
// A stalled output stops the sequencer; input is taken only between transactions.
module sql_statement_splitter_core
	import ssplit_pkg::*;
#(
	parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       kind,
	output logic [7:0] out_byte,
	output logic       hold_overflow,
	output logic       last
);

	cmd_t cmd;
	sts_t sts;

	ssplit_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ssplit_dp #(
		.HOLD_DEPTH (HOLD_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.action        (action),
		.in_byte       (in_byte),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.out_byte      (out_byte),
		.hold_overflow (hold_overflow),
		.last          (last)
	);

endmodule
